// ===== rtl/csdst_pkg.sv =====
`default_nettype none

package csdst_pkg;

   localparam int ADDR_W = 5;

   // request command codes
   localparam logic [1:0] CMD_PUT     = 2'd0;
   localparam logic [1:0] CMD_FILL    = 2'd1;
   localparam logic [1:0] CMD_REFRESH = 2'd2;
   localparam logic [1:0] CMD_READ    = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
   localparam logic [2:0] REG_CLIP_RIGHT  = 3'd1;
   localparam logic [2:0] REG_CLIP_TOP    = 3'd2;
   localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
   localparam logic [2:0] REG_LAST_ROW    = 3'd4;

   localparam logic [6:0] CLIP_LEFT_RST   = 7'd0;
   localparam logic [6:0] CLIP_RIGHT_RST  = 7'd127;
   localparam logic [4:0] CLIP_TOP_RST    = 5'd0;
   localparam logic [4:0] CLIP_BOTTOM_RST = 5'd31;
   localparam logic [4:0] LAST_ROW_RST    = 5'd31;

   typedef enum logic [1:0] {
      KIND_SPAN = 2'd0,
      KIND_DONE = 2'd1,
      KIND_READ = 2'd2
   } kind_type;

   typedef struct packed {
      logic [6:0] clip_left;
      logic [6:0] clip_right;
      logic [4:0] clip_top;
      logic [4:0] clip_bottom;
      logic [4:0] last_row;
   } cfg_type;

   typedef struct packed {
      logic     load_req;
      logic     put_commit;
      logic     fill_step;
      logic     dirty_rd_scan;
      logic     scan_next;
      logic     clear_step;
      logic     emit;
      kind_type emit_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic fill_ok;
      logic fill_last;
      logic scan_dirty;
      logic scan_last;
      logic rsp_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== rtl/csdst_regs.sv =====
`default_nettype none

module csdst_regs
   import csdst_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CLIP_LEFT:   cfg_in.clip_left   = pwdata[6:0];
            REG_CLIP_RIGHT:  cfg_in.clip_right  = pwdata[6:0];
            REG_CLIP_TOP:    cfg_in.clip_top    = pwdata[4:0];
            REG_CLIP_BOTTOM: cfg_in.clip_bottom = pwdata[4:0];
            REG_LAST_ROW:    cfg_in.last_row    = pwdata[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CLIP_LEFT:   prdata = 32'(cfg_ff.clip_left);
         REG_CLIP_RIGHT:  prdata = 32'(cfg_ff.clip_right);
         REG_CLIP_TOP:    prdata = 32'(cfg_ff.clip_top);
         REG_CLIP_BOTTOM: prdata = 32'(cfg_ff.clip_bottom);
         REG_LAST_ROW:    prdata = 32'(cfg_ff.last_row);
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_left   <= CLIP_LEFT_RST;
         cfg_ff.clip_right  <= CLIP_RIGHT_RST;
         cfg_ff.clip_top    <= CLIP_TOP_RST;
         cfg_ff.clip_bottom <= CLIP_BOTTOM_RST;
         cfg_ff.last_row    <= LAST_ROW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/csdst_datapath.sv =====
`default_nettype none

module csdst_datapath
   import csdst_pkg::*;
#(
   parameter int ROWS = 32,
   parameter int COLS = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  cfg_type         cfg,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   input  wire logic [4:0] req_row,
   input  wire logic [6:0] req_col,
   input  wire logic [6:0] req_col_end,
   input  wire logic [7:0] req_ch,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   output logic [1:0]      rsp_kind,
   output logic [4:0]      rsp_out_row,
   output logic [6:0]      rsp_span_left,
   output logic [6:0]      rsp_span_right,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_last
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [AW-1:0] COLS_A  = AW'(COLS);
   localparam logic [5:0]    ROWS_6  = 6'(ROWS);
   localparam logic [7:0]    COLS_8  = 8'(COLS);
   localparam logic [RW-1:0] ROW_MAX = RW'(ROWS - 1);
   localparam logic [AW-1:0] CLR_MAX = AW'(DEPTH - 1);

   // cell store and per-row dirty bounds {left, right}
   logic [7:0]  cell_mem  [DEPTH];
   logic [13:0] dirty_mem [ROWS];

   logic [4:0]      row_ff;
   logic [6:0]      col_ff;
   logic [6:0]      cend_ff;
   logic [7:0]      ch_ff;
   logic [6:0]      fill_x_ff;
   logic [6:0]      fill_lo_ff;
   logic [RW-1:0]   scan_ff;
   logic [AW-1:0]   clr_ff;
   logic [7:0]      cell_q_ff;
   logic [13:0]     dirty_q_ff;
   logic            dvq_ff;
   logic [ROWS-1:0] dv_ff;

   logic            rsp_valid_ff;
   kind_type        rsp_kind_ff;
   logic [4:0]      rsp_row_ff;
   logic [6:0]      rsp_left_ff;
   logic [6:0]      rsp_right_ff;
   logic [7:0]      rsp_char_ff;
   logic            rsp_last_ff;

   logic [6:0]      in_lo;
   logic [AW-1:0]   in_addr;
   logic [AW-1:0]   base;
   logic            row_in_clip;
   logic            row_ok;
   logic            col_ok;
   logic            put_ok;
   logic [6:0]      fill_hi;
   logic            fill_ok;
   logic            fill_last;
   logic            fill_col_ok;
   logic [6:0]      wid_lo;
   logic [6:0]      wid_hi;
   logic [6:0]      old_left;
   logic [6:0]      old_right;
   logic [13:0]     dirty_wd;
   logic            dirty_we;
   logic [RW-1:0]   dirty_wa;
   logic            dirty_re;
   logic [RW-1:0]   dirty_ra;
   logic            cell_we;
   logic [AW-1:0]   cell_wa;
   logic [7:0]      cell_wd;
   logic [RW-1:0]   scan_stop;

   assign in_lo   = (req_col > cfg.clip_left) ? req_col : cfg.clip_left;
   assign in_addr = AW'(req_row) * COLS_A + AW'(req_col);
   assign base    = AW'(row_ff) * COLS_A;

   assign row_in_clip = (row_ff >= cfg.clip_top) && (row_ff <= cfg.clip_bottom);
   assign row_ok      = {1'b0, row_ff} < ROWS_6;
   assign col_ok      = {1'b0, col_ff} < COLS_8;
   assign put_ok      = row_in_clip && row_ok && col_ok
                        && (col_ff >= cfg.clip_left) && (col_ff <= cfg.clip_right)
                        && (cell_q_ff != ch_ff);

   assign fill_hi     = (cend_ff < cfg.clip_right) ? cend_ff : cfg.clip_right;
   assign fill_ok     = row_in_clip && row_ok && (fill_hi >= fill_lo_ff);
   assign fill_last   = fill_x_ff == fill_hi;
   assign fill_col_ok = {1'b0, fill_x_ff} < COLS_8;

   // widen: a row without its valid bit is clean
   assign old_left  = dirty_q_ff[13:7];
   assign old_right = dirty_q_ff[6:0];
   assign wid_lo    = cmd.put_commit ? col_ff : fill_lo_ff;
   assign wid_hi    = cmd.put_commit ? col_ff : fill_hi;
   assign dirty_wd  = {(dvq_ff && old_left < wid_lo) ? old_left : wid_lo,
                       (dvq_ff && old_right > wid_hi) ? old_right : wid_hi};
   assign dirty_we  = (cmd.put_commit && put_ok) || (cmd.fill_step && fill_ok && fill_last);
   assign dirty_wa  = RW'(row_ff);
   assign dirty_re  = cmd.load_req || cmd.dirty_rd_scan;
   assign dirty_ra  = cmd.dirty_rd_scan ? scan_ff : RW'(req_row);

   assign cell_we = cmd.clear_step || (cmd.put_commit && put_ok)
                    || (cmd.fill_step && fill_ok && fill_col_ok);
   assign cell_wd = cmd.clear_step ? 8'd0 : ch_ff;

   always_comb begin
      if (cmd.clear_step) begin
         cell_wa = clr_ff;
      end else if (cmd.put_commit) begin
         cell_wa = base + AW'(col_ff);
      end else begin
         cell_wa = base + AW'(fill_x_ff);
      end
   end

   assign scan_stop = ({1'b0, cfg.last_row} < ROWS_6) ? RW'(cfg.last_row) : ROW_MAX;

   assign status.clear_done = clr_ff == CLR_MAX;
   assign status.fill_ok    = fill_ok;
   assign status.fill_last  = fill_last;
   assign status.scan_dirty = dvq_ff;
   assign status.scan_last  = scan_ff == scan_stop;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= cell_wd;
      end
      if (cmd.load_req) begin
         cell_q_ff <= cell_mem[in_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dirty_we) begin
         dirty_mem[dirty_wa] <= dirty_wd;
      end
      if (dirty_re) begin
         dirty_q_ff <= dirty_mem[dirty_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (dirty_re) begin
         dvq_ff <= dv_ff[dirty_ra];
      end
      if (cmd.load_req) begin
         row_ff     <= req_row;
         col_ff     <= req_col;
         cend_ff    <= req_col_end;
         ch_ff      <= req_ch;
         fill_lo_ff <= in_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff     <= '0;
         clr_ff    <= '0;
         scan_ff   <= '0;
         fill_x_ff <= '0;
      end else begin
         if (dirty_we) begin
            dv_ff[dirty_wa] <= 1'b1;
         end
         if (cmd.scan_next) begin
            dv_ff[scan_ff] <= 1'b0;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.load_req) begin
            scan_ff   <= '0;
            fill_x_ff <= in_lo;
         end else begin
            if (cmd.scan_next) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (cmd.fill_step) begin
               fill_x_ff <= fill_x_ff + 1'b1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff <= cmd.emit_kind;
         case (cmd.emit_kind)
            KIND_SPAN: begin
               rsp_row_ff   <= 5'(scan_ff);
               rsp_left_ff  <= old_left;
               rsp_right_ff <= old_right;
               rsp_char_ff  <= 8'd0;
               rsp_last_ff  <= 1'b0;
            end
            KIND_READ: begin
               rsp_row_ff   <= row_ff;
               rsp_left_ff  <= 7'd0;
               rsp_right_ff <= 7'd0;
               rsp_char_ff  <= (row_ok && col_ok) ? cell_q_ff : 8'd0;
               rsp_last_ff  <= 1'b1;
            end
            default: begin
               rsp_row_ff   <= 5'd0;
               rsp_left_ff  <= 7'd0;
               rsp_right_ff <= 7'd0;
               rsp_char_ff  <= 8'd0;
               rsp_last_ff  <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_span_left  = rsp_left_ff;
   assign rsp_span_right = rsp_right_ff;
   assign rsp_char_out   = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/csdst_ctrl.sv =====
`default_nettype none

module csdst_ctrl
   import csdst_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_command,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_PUT     = 8'b0000_0100,
      ST_FILL    = 8'b0000_1000,
      ST_SCAN_RD = 8'b0001_0000,
      ST_SCAN_EV = 8'b0010_0000,
      ST_DONE    = 8'b0100_0000,
      ST_READ    = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_command)
                  CMD_PUT:     state_in = ST_PUT;
                  CMD_FILL:    state_in = ST_FILL;
                  CMD_REFRESH: state_in = ST_SCAN_RD;
                  CMD_READ:    state_in = ST_READ;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_PUT: begin
            cmd.put_commit = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (!status.fill_ok || status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            cmd.dirty_rd_scan = 1'b1;
            state_in = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            // a dirty row waits for the result slot; a clean one just moves on
            if (!status.scan_dirty || status.rsp_free) begin
               cmd.emit      = status.scan_dirty;
               cmd.emit_kind = KIND_SPAN;
               cmd.scan_next = 1'b1;
               state_in = status.scan_last ? ST_DONE : ST_SCAN_RD;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_DONE;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (status.rsp_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_READ;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/char_screen_dirty_span_tracker_core.sv =====
`default_nettype none

// Channel   Ports                    Moves
// req       req_valid / req_ready    one request: command, row, col, col_end, ch
// rsp       rsp_valid / rsp_ready    span, refresh done or read data item
// csr       psel/penable/pwrite      register write/read, pready tied high
//
// Put writes its cell and read emits its item after the request is loaded; fill
// writes one cell per cycle over the clamped run. Refresh reads each row's dirty
// bounds up to last_row and emits a span per dirty row, then a done item.
// After reset all cells are zeroed with req_ready low; registers stay writable.
// Span, done and read items wait in the result register while rsp_ready is low;
// a refresh or read stalls only when it must emit while a result still waits.

module char_screen_dirty_span_tracker_core
   import csdst_pkg::*;
#(
   parameter int ROWS = 32,
   parameter int COLS = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [4:0]        req_row,
   input  wire logic [6:0]        req_col,
   input  wire logic [6:0]        req_col_end,
   input  wire logic [7:0]        req_ch,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_kind,
   output logic [4:0]             rsp_out_row,
   output logic [6:0]             rsp_span_left,
   output logic [6:0]             rsp_span_right,
   output logic [7:0]             rsp_char_out,
   output logic                   rsp_last,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   cfg_type         cfg;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   csdst_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   csdst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   csdst_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_col_end    (req_col_end),
      .req_ch         (req_ch),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_out_row    (rsp_out_row),
      .rsp_span_left  (rsp_span_left),
      .rsp_span_right (rsp_span_right),
      .rsp_char_out   (rsp_char_out),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
